>>> rtl/ids_pkg.sv
// Shared types, widths and request codes of the indexed deque store.
package ids_pkg;

  // Fixed field widths of the request and result channels.
  localparam int REQ_W      = 4;
  localparam int POS_W      = 5;
  localparam int PORT_REC_W = 32;
  localparam int COUNT_W    = 5;
  localparam int STATUS_W   = 2;

  // Default storage shape.
  localparam int DEF_DEPTH        = 16;
  localparam int DEF_RECORD_WIDTH = 32;

  // Request kinds carried in req_type.
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_BACK  = 4'd0,
    REQ_PUSH_FRONT = 4'd1,
    REQ_POP_BACK   = 4'd2,
    REQ_POP_FRONT  = 4'd3,
    REQ_INSERT_AT  = 4'd4,
    REQ_DELETE_AT  = 4'd5,
    REQ_GET_AT     = 4'd6,
    REQ_PEEK_FRONT = 4'd7,
    REQ_PEEK_BACK  = 4'd8,
    REQ_CLEAR      = 4'd9
  } req_kind_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // One finished result as handed to the output stage.
  typedef struct packed {
    logic [PORT_REC_W-1:0] record_out;
    logic [COUNT_W-1:0]    entry_count;
    status_t               status;
  } rsp_t;

endpackage

>>> rtl/ids_req_if.sv
// Request channel of the indexed deque store.
interface ids_req_if
  import ids_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [REQ_W-1:0]      req_type;
  logic [POS_W-1:0]      position;
  logic [PORT_REC_W-1:0] record_in;

  modport source (output valid, output req_type, output position, output record_in,
                  input ready);
  modport sink (input valid, input req_type, input position, input record_in,
                output ready);
endinterface

>>> rtl/ids_rsp_if.sv
// Result channel of the indexed deque store.
interface ids_rsp_if
  import ids_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [PORT_REC_W-1:0] record_out;
  logic [COUNT_W-1:0]    entry_count;
  logic [STATUS_W-1:0]   status;

  modport source (output valid, output record_out, output entry_count, output status,
                  input ready);
  modport sink (input valid, input record_out, input entry_count, input status,
                output ready);
endinterface

>>> rtl/ids_out_reg.sv
// Output register that holds one finished result until the consumer takes it.
module ids_out_reg
  import ids_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            ld_valid,
  output logic            ld_ready,
  input  rsp_t            ld_data,
  ids_rsp_if.source       out_rsp
);

  logic valid_r;
  rsp_t data_r;

  // A new result may enter when the register is empty or is being drained.
  assign ld_ready = !valid_r || out_rsp.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ld_ready) begin
      valid_r <= ld_valid;
    end
    if (ld_ready && ld_valid) begin
      data_r <= ld_data;
    end
  end

  // Drive the result channel from the register.
  assign out_rsp.valid       = valid_r;
  assign out_rsp.record_out  = data_r.record_out;
  assign out_rsp.entry_count = data_r.entry_count;
  assign out_rsp.status      = data_r.status;

endmodule

>>> rtl/indexed_deque_store_core.sv
// Indexed deque store: an ordered store of up to DEPTH records in one
// memory with one write and one registered read port. One request is
// taken at a time. A small sequencer shifts records one slot per cycle
// through the memory ports: push_front, pop_front, insert and delete move
// each record between the index and the back of the store, while
// push_back, pop_back, get, peek, clear and all errors move none. The
// result sits in an output register, so the next request is taken while
// the previous result still waits to be read.
module indexed_deque_store_core
  import ids_pkg::*;
#(
  parameter int DEPTH        = DEF_DEPTH,
  parameter int RECORD_WIDTH = DEF_RECORD_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  ids_req_if.sink   in_req,
  ids_rsp_if.source out_rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_UP_WR,
    S_FILL,
    S_RD_WAIT,
    S_DN_WR,
    S_DONE
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  req_kind_t               op_r, op_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [RECORD_WIDTH-1:0] rec_r, rec_nxt;
  logic [AW-1:0]           at_r, at_nxt;
  logic [AW-1:0]           cur_r, cur_nxt;
  logic [RECORD_WIDTH-1:0] data_r, data_nxt;
  status_t                 status_r, status_nxt;

  // Record memory and its port controls.
  logic [RECORD_WIDTH-1:0] mem [DEPTH];
  logic [RECORD_WIDTH-1:0] rd_data_r;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [RECORD_WIDTH-1:0] mem_wdata;
  logic                    mem_re;
  logic [AW-1:0]           mem_raddr;

  logic    in_acc;
  logic    ld_valid;
  logic    ld_ready;
  rsp_t    ld_data;
  logic    full;
  logic    empty;
  logic [AW-1:0] last_idx;
  logic [AW-1:0] cnt_idx;
  logic [AW-1:0] cur_dec;
  logic [AW-1:0] ins_at;
  logic [PW-1:0] pos_ext;
  logic [PW-1:0] cnt_ext;
  logic [PW-1:0] cur1_ext;
  logic [PW-1:0] cur2_ext;

  assign in_req.ready = (state_r == S_IDLE);
  assign in_acc       = in_req.valid && in_req.ready;

  // Index arithmetic shared by the sequencer states.
  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign last_idx = AW'(count_r - CW'(1));
  assign cnt_idx  = AW'(count_r);
  assign cur_dec  = cur_r - AW'(1);
  assign pos_ext  = PW'(pos_r);
  assign cnt_ext  = PW'(count_r);
  assign cur1_ext = PW'(cur_r) + PW'(1);
  assign cur2_ext = PW'(cur_r) + PW'(2);

  always_comb begin
    case (op_r)
      REQ_PUSH_BACK:  ins_at = cnt_idx;
      REQ_PUSH_FRONT: ins_at = '0;
      default:        ins_at = AW'(pos_r);
    endcase
  end

  // Sequencer: decode the request, then move records one slot per cycle.
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    op_nxt     = op_r;
    pos_nxt    = pos_r;
    rec_nxt    = rec_r;
    at_nxt     = at_r;
    cur_nxt    = cur_r;
    data_nxt   = data_r;
    status_nxt = status_r;
    mem_we     = 1'b0;
    mem_waddr  = cur_r;
    mem_wdata  = rd_data_r;
    mem_re     = 1'b0;
    mem_raddr  = cur_dec;
    ld_valid   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = req_kind_t'(in_req.req_type);
          pos_nxt   = in_req.position;
          rec_nxt   = RECORD_WIDTH'(in_req.record_in);
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        data_nxt   = '0;
        status_nxt = ST_OK;
        state_nxt  = S_DONE;
        case (op_r)
          REQ_PUSH_BACK, REQ_PUSH_FRONT, REQ_INSERT_AT: begin
            if (op_r == REQ_INSERT_AT && pos_ext > cnt_ext) begin
              status_nxt = ST_RANGE;
            end else if (full) begin
              status_nxt = ST_FULL;
            end else begin
              at_nxt  = ins_at;
              cur_nxt = cnt_idx;
              if (cnt_idx == ins_at) begin
                state_nxt = S_FILL;
              end else begin
                // Fetch the record that moves into the slot at the back.
                mem_re    = 1'b1;
                mem_raddr = cnt_idx - AW'(1);
                state_nxt = S_UP_WR;
              end
            end
          end
          REQ_POP_BACK, REQ_POP_FRONT, REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
            if (empty) begin
              status_nxt = ST_RANGE;
            end else begin
              mem_re = 1'b1;
              if (op_r == REQ_POP_BACK || op_r == REQ_PEEK_BACK) begin
                mem_raddr = last_idx;
                cur_nxt   = last_idx;
              end else begin
                mem_raddr = '0;
                cur_nxt   = '0;
              end
              state_nxt = S_RD_WAIT;
            end
          end
          REQ_DELETE_AT, REQ_GET_AT: begin
            if (pos_ext >= cnt_ext) begin
              status_nxt = ST_RANGE;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = AW'(pos_r);
              cur_nxt   = AW'(pos_r);
              state_nxt = S_RD_WAIT;
            end
          end
          REQ_CLEAR: begin
            count_nxt = '0;
          end
          default: begin
            status_nxt = ST_RANGE;
          end
        endcase
      end

      // Open a gap: write each fetched record one slot further back.
      S_UP_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cur_r;
        mem_wdata = rd_data_r;
        cur_nxt   = cur_dec;
        if (cur_dec == at_r) begin
          state_nxt = S_FILL;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = cur_dec - AW'(1);
        end
      end

      // Store the new record in the gap.
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = at_r;
        mem_wdata = rec_r;
        count_nxt = count_r + CW'(1);
        state_nxt = S_DONE;
      end

      // The addressed record has arrived from the memory.
      S_RD_WAIT: begin
        data_nxt  = rd_data_r;
        state_nxt = S_DONE;
        case (op_r)
          REQ_POP_BACK: begin
            count_nxt = count_r - CW'(1);
          end
          REQ_POP_FRONT, REQ_DELETE_AT: begin
            if (cur1_ext < cnt_ext) begin
              mem_re    = 1'b1;
              mem_raddr = AW'(cur1_ext);
              state_nxt = S_DN_WR;
            end else begin
              count_nxt = count_r - CW'(1);
            end
          end
          default: begin
          end
        endcase
      end

      // Close a gap: write each fetched record one slot further forward.
      S_DN_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cur_r;
        mem_wdata = rd_data_r;
        cur_nxt   = AW'(cur1_ext);
        if (cur2_ext < cnt_ext) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(cur2_ext);
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end
      end

      // Hand the result to the output register.
      S_DONE: begin
        ld_valid = 1'b1;
        if (ld_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    op_r     <= op_nxt;
    pos_r    <= pos_nxt;
    rec_r    <= rec_nxt;
    at_r     <= at_nxt;
    cur_r    <= cur_nxt;
    data_r   <= data_nxt;
    status_r <= status_nxt;
  end

  // Memory write port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // Memory read port with registered data.
  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // Result as seen by the output register.
  assign ld_data.record_out  = PORT_REC_W'(data_r);
  assign ld_data.entry_count = COUNT_W'(count_r);
  assign ld_data.status      = status_r;

  ids_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .ld_valid (ld_valid),
    .ld_ready (ld_ready),
    .ld_data  (ld_data),
    .out_rsp  (out_rsp)
  );

`ifndef SYNTHESIS
  // The count never exceeds the capacity of the store.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("record count above capacity");

  // An accepted request always starts the sequencer.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_EXEC)
    else $error("accepted request did not start the sequencer");

  // Opening a gap never passes the insert position.
  a_up_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UP_WR |-> cur_r > at_r)
    else $error("gap opening moved past the insert position");

  // Closing a gap never reads beyond the last held record.
  a_dn_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DN_WR |-> cur1_ext < cnt_ext)
    else $error("gap closing moved past the last record");

  // The count changes only while a request is being worked on.
  a_count_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |=> $stable(count_r))
    else $error("record count changed outside a request");
`endif

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the indexed deque store core.
module tb_top;
  import ids_pkg::*;

  localparam int DEPTH       = DEF_DEPTH;
  localparam int GEN         = 0;     // store copy used to steer the stimulus
  localparam int CHK         = 1;     // store copy used to predict results
  localparam int HOLD_AT     = 900;   // result count at which the long hold-off starts
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 64;
  localparam int IDLE_LIMIT  = 4000;

  // Request codes past the last defined kind.
  localparam logic [REQ_W-1:0] REQ_UNKNOWN_LO = 4'd10;
  localparam logic [REQ_W-1:0] REQ_UNKNOWN_HI = 4'd15;

  typedef struct packed {
    logic                  drain;     // hold this request until all results are back
    logic [REQ_W-1:0]      kind;
    logic [POS_W-1:0]      pos;
    logic [PORT_REC_W-1:0] rec;
  } deque_req_t;

  typedef enum int {
    MIX_ANY,
    FILL_UP,
    DRAIN_DOWN,
    STACK_USE,
    QUEUE_USE,
    NOISE
  } burst_mode_t;

  logic clk;
  logic rst_n;

  ids_req_if req_ch ();
  ids_rsp_if rsp_ch ();

  indexed_deque_store_core uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  // Two copies of the store contents: one steers generation, one predicts.
  logic [PORT_REC_W-1:0] deque_rec [2][DEPTH];
  int unsigned           deque_cnt [2];

  deque_req_t pending_reqs[$];
  rsp_t       predicted_rsp[$];

  int unsigned n_total      = 0;
  int unsigned n_sent       = 0;
  int unsigned n_checked    = 0;
  int          outstanding  = 0;
  int unsigned fail_count   = 0;
  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;
  int unsigned hold_left    = 0;
  int unsigned idle_cycles  = 0;
  bit          src_gaps_on  = 1'b1;
  bit          sink_stalls_on = 1'b1;

  // Open a hole at index at, store the record there and grow the store.
  function automatic void shift_in(int s, int unsigned at, logic [PORT_REC_W-1:0] rec);
    int unsigned i;
    for (i = deque_cnt[s]; i > at; i--) begin
      deque_rec[s][i] = deque_rec[s][i-1];
    end
    deque_rec[s][at] = rec;
    deque_cnt[s]++;
  endfunction

  // Close the hole at index at and shrink the store.
  function automatic void shift_out(int s, int unsigned at);
    int unsigned i;
    for (i = at; i + 1 < deque_cnt[s]; i++) begin
      deque_rec[s][i] = deque_rec[s][i+1];
    end
    deque_cnt[s]--;
  endfunction

  // Apply one request to store copy s and return the result it produces.
  function automatic rsp_t apply_request(int s, deque_req_t it);
    rsp_t        r;
    int unsigned n;
    int unsigned p;
    r.record_out = '0;
    r.status     = ST_OK;
    n = deque_cnt[s];
    p = it.pos;
    case (it.kind)
      REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
        if (n >= DEPTH) r.status = ST_FULL;
        else shift_in(s, (it.kind == REQ_PUSH_BACK) ? n : 0, it.rec);
      end
      REQ_POP_BACK: begin
        if (n == 0) r.status = ST_RANGE;
        else begin
          r.record_out = deque_rec[s][n-1];
          deque_cnt[s]--;
        end
      end
      REQ_POP_FRONT: begin
        if (n == 0) r.status = ST_RANGE;
        else begin
          r.record_out = deque_rec[s][0];
          shift_out(s, 0);
        end
      end
      REQ_INSERT_AT: begin
        // The index check wins over the full check.
        if (p > n) r.status = ST_RANGE;
        else if (n >= DEPTH) r.status = ST_FULL;
        else shift_in(s, p, it.rec);
      end
      REQ_DELETE_AT: begin
        if (p >= n) r.status = ST_RANGE;
        else begin
          r.record_out = deque_rec[s][p];
          shift_out(s, p);
        end
      end
      REQ_GET_AT: begin
        if (p >= n) r.status = ST_RANGE;
        else r.record_out = deque_rec[s][p];
      end
      REQ_PEEK_FRONT: begin
        if (n == 0) r.status = ST_RANGE;
        else r.record_out = deque_rec[s][0];
      end
      REQ_PEEK_BACK: begin
        if (n == 0) r.status = ST_RANGE;
        else r.record_out = deque_rec[s][n-1];
      end
      REQ_CLEAR: begin
        deque_cnt[s] = 0;
      end
      default: begin
        r.status = ST_RANGE;
      end
    endcase
    r.entry_count = COUNT_W'(deque_cnt[s]);
    return r;
  endfunction

  // Append a request to the stimulus and track its effect on the steering copy.
  function automatic void queue_request(logic [REQ_W-1:0] kind, logic [POS_W-1:0] pos,
                                        logic [PORT_REC_W-1:0] rec, logic drain);
    deque_req_t it;
    it.drain = drain;
    it.kind  = kind;
    it.pos   = pos;
    it.rec   = rec;
    pending_reqs.push_back(it);
    void'(apply_request(GEN, it));
  endfunction

  // Record values lean toward the extremes now and then.
  function automatic logic [PORT_REC_W-1:0] random_record();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stimulus generation, reset and end of run.
  initial begin
    int unsigned n_rand;
    int unsigned burst_no;
    int unsigned burst_len;
    int unsigned j;
    int unsigned n;
    int unsigned r;
    burst_mode_t mode;
    logic [REQ_W-1:0] kind;
    logic [POS_W-1:0] pos;
    logic drain;

    rst_n            = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = '0;
    req_ch.position  = '0;
    req_ch.record_in = '0;
    rsp_ch.ready     = 1'b0;
    deque_cnt[GEN]   = 0;
    deque_cnt[CHK]   = 0;

    // Directed part: empty store errors, index edges, both ends, unknown codes and clear.
    queue_request(REQ_POP_BACK,   5'd0,  '0, 1'b0);
    queue_request(REQ_POP_FRONT,  5'd0,  '0, 1'b0);
    queue_request(REQ_PEEK_FRONT, 5'd0,  '0, 1'b0);
    queue_request(REQ_PEEK_BACK,  5'd0,  '0, 1'b0);
    queue_request(REQ_GET_AT,     5'd0,  '0, 1'b0);
    queue_request(REQ_DELETE_AT,  5'd0,  '0, 1'b0);
    queue_request(REQ_INSERT_AT,  5'd1,  32'hDEAD_BEEF, 1'b0);
    queue_request(REQ_INSERT_AT,  5'd0,  32'hFFFF_FFFF, 1'b0);
    queue_request(REQ_PUSH_FRONT, 5'd0,  32'h0000_0000, 1'b0);
    queue_request(REQ_PUSH_BACK,  5'd31, 32'h1234_5678, 1'b0);
    queue_request(REQ_INSERT_AT,  5'd3,  32'hA5A5_A5A5, 1'b0);
    queue_request(REQ_INSERT_AT,  5'd1,  32'h5A5A_5A5A, 1'b0);
    queue_request(REQ_GET_AT,     5'd4,  '0, 1'b0);
    queue_request(REQ_GET_AT,     5'd5,  '0, 1'b0);
    queue_request(REQ_DELETE_AT,  5'd31, '0, 1'b0);
    queue_request(REQ_GET_AT,     5'd16, '0, 1'b0);
    queue_request(REQ_PEEK_FRONT, 5'd0,  '0, 1'b0);
    queue_request(REQ_PEEK_BACK,  5'd0,  '0, 1'b0);
    queue_request(REQ_DELETE_AT,  5'd2,  '0, 1'b0);
    queue_request(REQ_POP_FRONT,  5'd0,  '0, 1'b0);
    queue_request(REQ_POP_BACK,   5'd0,  '0, 1'b0);
    queue_request(REQ_UNKNOWN_LO, 5'd0,  32'hFFFF_FFFF, 1'b0);
    queue_request(REQ_UNKNOWN_HI, 5'd31, 32'hFFFF_FFFF, 1'b0);
    queue_request(REQ_CLEAR,      5'd0,  '0, 1'b0);
    queue_request(REQ_PEEK_BACK,  5'd0,  '0, 1'b0);

    // Random part: bursts that fill, drain or exercise the store in one style.
    n_rand   = 0;
    burst_no = 0;
    while (n_rand < 1575) begin
      mode      = burst_mode_t'($urandom_range(0, 5));
      burst_len = $urandom_range(8, 48);
      for (j = 0; j < burst_len; j++) begin
        n    = deque_cnt[GEN];
        r    = $urandom_range(0, 9);
        pos  = '0;
        drain = (j == 0) && (burst_no % 8 == 0);
        case (mode)
          FILL_UP: begin
            if (r < 4) kind = REQ_PUSH_BACK;
            else if (r < 6) kind = REQ_PUSH_FRONT;
            else if (r < 9) begin
              kind = REQ_INSERT_AT;
              pos  = POS_W'($urandom_range(0, n));
            end else begin
              kind = REQ_GET_AT;
              pos  = (n > 0) ? POS_W'($urandom_range(0, n - 1)) : '0;
            end
          end
          DRAIN_DOWN: begin
            if (r < 3) kind = REQ_POP_FRONT;
            else if (r < 5) kind = REQ_POP_BACK;
            else if (r < 8) begin
              kind = REQ_DELETE_AT;
              pos  = (n > 0) ? POS_W'($urandom_range(0, n - 1)) : '0;
            end else kind = (r == 8) ? REQ_PEEK_FRONT : REQ_PEEK_BACK;
          end
          STACK_USE: begin
            if (r < 5) kind = REQ_PUSH_BACK;
            else if (r < 9) kind = REQ_POP_BACK;
            else kind = REQ_PEEK_BACK;
          end
          QUEUE_USE: begin
            if (r < 5) kind = REQ_PUSH_BACK;
            else if (r < 9) kind = REQ_POP_FRONT;
            else kind = REQ_PEEK_FRONT;
          end
          MIX_ANY: begin
            kind = REQ_W'($urandom_range(0, REQ_CLEAR));
            // Keep clears rare so the store holds records most of the time.
            if (kind == REQ_CLEAR && $urandom_range(0, 3) != 0) kind = REQ_GET_AT;
            if ($urandom_range(0, 7) == 0) pos = POS_W'($urandom_range(0, 31));
            else pos = POS_W'($urandom_range(0, n));
          end
          default: begin
            kind = REQ_W'($urandom_range(0, REQ_UNKNOWN_HI));
            pos  = POS_W'($urandom_range(0, 31));
          end
        endcase
        queue_request(kind, pos, random_record(), drain);
        n_rand++;
      end
      burst_no++;
    end
    n_total = pending_reqs.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    wait (n_sent == n_total && outstanding == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("indexed_deque_store_core test passed");
    end else begin
      $display("indexed_deque_store_core test failed");
    end
    $finish;
  end

  // Request driver: offers the head of the pending list after a random gap.
  always @(posedge clk) begin
    logic offer;
    deque_req_t nxt;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      offer = req_ch.valid;
      if (req_ch.valid && req_ch.ready) begin
        predicted_rsp.push_back(apply_request(CHK, pending_reqs.pop_front()));
        outstanding++;
        n_sent++;
        offer = 1'b0;
        if (n_sent % 64 == 0) src_gaps_on = ($urandom_range(0, 2) != 0);
        gap_left = src_gaps_on ? $urandom_range(0, 7) : 0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].drain && outstanding > 0)) begin
          nxt = pending_reqs[0];
          req_ch.req_type  <= nxt.kind;
          req_ch.position  <= nxt.pos;
          req_ch.record_in <= nxt.rec;
          offer = 1'b1;
        end
      end
      req_ch.valid <= offer;
    end
  end

  // Result monitor: checks each result against the oldest prediction.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (predicted_rsp.size() == 0) begin
          $display("%0t: unexpected result, expected none, got record %h count %0d status %0d",
                   $time, rsp_ch.record_out, rsp_ch.entry_count, rsp_ch.status);
          fail_count++;
        end else begin
          want = predicted_rsp.pop_front();
          outstanding--;
          if (rsp_ch.record_out !== want.record_out) begin
            $display("%0t: record_out mismatch, expected %h, got %h",
                     $time, want.record_out, rsp_ch.record_out);
            fail_count++;
          end
          if (rsp_ch.entry_count !== want.entry_count) begin
            $display("%0t: entry_count mismatch, expected %0d, got %0d",
                     $time, want.entry_count, rsp_ch.entry_count);
            fail_count++;
          end
          if (rsp_ch.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, rsp_ch.status);
            fail_count++;
          end
        end
        n_checked++;
        // One long hold-off lets the block back up and stall its input.
        if (n_checked == HOLD_AT) hold_left = HOLD_CYCLES;
        if (n_checked % 64 == 0) sink_stalls_on = ($urandom_range(0, 2) != 0);
        stall_left = sink_stalls_on ? $urandom_range(0, 7) : 0;
      end else if (hold_left > 0) begin
        hold_left--;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      rsp_ch.ready <= (stall_left == 0 && hold_left == 0);
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no request or result moved for %0d cycles", $time, IDLE_LIMIT);
        $display("indexed_deque_store_core test failed");
        $finish;
      end
    end
  end

endmodule
